// File: rtl/idmix_pkg.sv
// Shared types and constants for the chained splitmix64 identifier derivation block.
package idmix_pkg;

   // Mixing constants.
   localparam logic [63:0] GAMMA_ADD = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MUL_ONE   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MUL_TWO   = 64'h94d049bb133111eb;
   localparam logic [63:0] HIGH_SALT = 64'h2545f4914f6cdd1d;
   localparam int unsigned SHIFT_ONE   = 30;
   localparam int unsigned SHIFT_TWO   = 27;
   localparam int unsigned SHIFT_THREE = 31;

   // Item command codes.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TAG   = 1'b1;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD_HI,
      OP_SUM_LO,
      OP_LOAD_LO,
      OP_MUL0,
      OP_MUL1,
      OP_MUL2,
      OP_EMIT
   } op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type op;
      logic   k_two;    // second multiply of the finalizer
      logic   dest_hi;  // final write goes to the high half
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;       // captured word is marked last
      logic rsp_busy;   // output register holds a word that is not taken this cycle
   } dp_status_type;

   // XOR of a value with itself shifted right.
   function automatic logic [63:0] xor_shift(input logic [63:0] v, input int unsigned sh);
      return v ^ (v >> sh);
   endfunction

endpackage

// File: rtl/idmix_dp.sv
// Datapath: input capture, accumulator halves, shared 32x32 multiplier and output register.
module idmix_dp
   import idmix_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          req_cmd,
   input  logic [63:0]   req_parent_high,
   input  logic [63:0]   req_parent_low,
   input  logic [7:0]    req_tag_byte,
   input  logic          req_last,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [63:0]   rsp_id_high,
   output logic [63:0]   rsp_id_low
);

   // Captured input word.
   logic        cmd_ff, cmd_in;
   logic [63:0] ph_ff, ph_in;
   logic [63:0] pl_ff, pl_in;
   logic [7:0]  tb_ff, tb_in;
   logic        last_ff, last_in;

   // Working value, partial product and accumulator.
   logic [63:0] v_ff, v_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_high_ff, acc_high_in;
   logic [63:0] acc_low_ff, acc_low_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_high_ff, rsp_high_in;
   logic [63:0] rsp_low_ff, rsp_low_in;

   logic [63:0] k_const;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] hi_src;
   logic [63:0] prod_sum;

   // Shared multiplier: low 64 bits of v * k in three partial products.
   always_comb begin
      k_const = cmd.k_two ? MUL_TWO : MUL_ONE;
      mul_a   = (cmd.op == OP_MUL1) ? v_ff[63:32] : v_ff[31:0];
      mul_b   = (cmd.op == OP_MUL2) ? k_const[63:32] : k_const[31:0];
      mul_p   = mul_a * mul_b;
      prod_sum = prod_ff + {mul_p[31:0], 32'd0};
      hi_src  = (cmd_ff == CMD_TAG) ? (acc_high_ff ^ {56'd0, tb_ff})
                                    : (ph_ff ^ HIGH_SALT);
   end

   // Next-state logic for all datapath registers.
   always_comb begin
      cmd_in       = cmd_ff;
      ph_in        = ph_ff;
      pl_in        = pl_ff;
      tb_in        = tb_ff;
      last_in      = last_ff;
      v_in         = v_ff;
      prod_in      = prod_ff;
      acc_high_in  = acc_high_ff;
      acc_low_in   = acc_low_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_high_in  = rsp_high_ff;
      rsp_low_in   = rsp_low_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            cmd_in  = req_cmd;
            ph_in   = req_parent_high;
            pl_in   = req_parent_low;
            tb_in   = req_tag_byte;
            last_in = req_last;
         end
         OP_LOAD_HI: v_in = xor_shift(hi_src + GAMMA_ADD, SHIFT_ONE);
         OP_SUM_LO:  v_in = (cmd_ff == CMD_TAG) ? (acc_low_ff + acc_high_ff) : pl_ff;
         OP_LOAD_LO: v_in = xor_shift(v_ff + GAMMA_ADD, SHIFT_ONE);
         OP_MUL0:    prod_in = mul_p;
         OP_MUL1:    prod_in = prod_sum;
         OP_MUL2: begin
            if (!cmd.k_two) begin
               v_in = xor_shift(prod_sum, SHIFT_TWO);
            end else if (cmd.dest_hi) begin
               acc_high_in = xor_shift(prod_sum, SHIFT_THREE);
            end else begin
               acc_low_in = xor_shift(prod_sum, SHIFT_THREE);
            end
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_low_in   = acc_low_ff;
            // An all-zero identifier is reported with a high half of one.
            rsp_high_in  = (acc_high_ff == 64'd0 && acc_low_ff == 64'd0) ? 64'd1
                                                                          : acc_high_ff;
         end
         default: ;
      endcase
   end

   // Control state and accumulator are cleared; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_high_ff  <= '0;
         acc_low_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_high_ff  <= acc_high_in;
         acc_low_ff   <= acc_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      ph_ff       <= ph_in;
      pl_ff       <= pl_in;
      tb_ff       <= tb_in;
      last_ff     <= last_in;
      v_ff        <= v_in;
      prod_ff     <= prod_in;
      rsp_high_ff <= rsp_high_in;
      rsp_low_ff  <= rsp_low_in;
   end

   assign status.last     = last_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_id_high     = rsp_high_ff;
   assign rsp_id_low      = rsp_low_ff;

endmodule

// File: rtl/idmix_ctrl.sv
// Controller: sequences the two mixing rounds of each word over the shared multiplier.
module idmix_ctrl
   import idmix_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_HI_LOAD,
      S_HI_A0, S_HI_A1, S_HI_A2,
      S_HI_B0, S_HI_B1, S_HI_B2,
      S_LO_SUM,
      S_LO_LOAD,
      S_LO_A0, S_LO_A1, S_LO_A2,
      S_LO_B0, S_LO_B1, S_LO_B2,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Next state and the command for the current state.
   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NONE;
      cmd.k_two   = 1'b0;
      cmd.dest_hi = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_HI_LOAD;
            end
         end
         S_HI_LOAD: begin cmd.op = OP_LOAD_HI; state_in = S_HI_A0; end
         S_HI_A0:   begin cmd.op = OP_MUL0; state_in = S_HI_A1; end
         S_HI_A1:   begin cmd.op = OP_MUL1; state_in = S_HI_A2; end
         S_HI_A2:   begin cmd.op = OP_MUL2; state_in = S_HI_B0; end
         S_HI_B0:   begin cmd.op = OP_MUL0; cmd.k_two = 1'b1; state_in = S_HI_B1; end
         S_HI_B1:   begin cmd.op = OP_MUL1; cmd.k_two = 1'b1; state_in = S_HI_B2; end
         S_HI_B2: begin
            cmd.op      = OP_MUL2;
            cmd.k_two   = 1'b1;
            cmd.dest_hi = 1'b1;
            state_in    = S_LO_SUM;
         end
         S_LO_SUM:  begin cmd.op = OP_SUM_LO; state_in = S_LO_LOAD; end
         S_LO_LOAD: begin cmd.op = OP_LOAD_LO; state_in = S_LO_A0; end
         S_LO_A0:   begin cmd.op = OP_MUL0; state_in = S_LO_A1; end
         S_LO_A1:   begin cmd.op = OP_MUL1; state_in = S_LO_A2; end
         S_LO_A2:   begin cmd.op = OP_MUL2; state_in = S_LO_B0; end
         S_LO_B0:   begin cmd.op = OP_MUL0; cmd.k_two = 1'b1; state_in = S_LO_B1; end
         S_LO_B1:   begin cmd.op = OP_MUL1; cmd.k_two = 1'b1; state_in = S_LO_B2; end
         S_LO_B2: begin
            cmd.op    = OP_MUL2;
            cmd.k_two = 1'b1;
            state_in  = status.last ? S_EMIT : S_IDLE;
         end
         // Wait until the output register is free, then load it.
         S_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: rtl/id_derive_mix_hash_core.sv
// Top level of the chained splitmix64 identifier derivation block.
//
// Input channel (req_*): one word per valid/ready handshake. A word with cmd 0
// loads both halves from the parent identifier; a word with cmd 1 absorbs
// tag_byte into the running halves. A word marked last produces one result.
// Result channel (rsp_*): one word holding the 128-bit identifier, sent from
// an output register with valid/ready.
// A word is accepted only while the controller is idle, so a new word waits
// until the previous one is worked through and, if it is marked last, loaded
// into the output register. The single 32x32 multiplier sets the pace: each
// of the four 64-bit multiplies is three partial products, plus a load step
// per round and one sum step for the low half.
// Reset clears both halves to zero and empties the output register.
// When the receiver stalls, the result waits in the output register; a new
// word is still accepted and worked on, and only its own emission waits.
module id_derive_mix_hash_core
   import idmix_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [63:0] req_parent_high,
   input  logic [63:0] req_parent_low,
   input  logic [7:0]  req_tag_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_id_high,
   output logic [63:0] rsp_id_low
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer.
   idmix_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   // Arithmetic and storage.
   idmix_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_cmd         (req_cmd),
      .req_parent_high (req_parent_high),
      .req_parent_low  (req_parent_low),
      .req_tag_byte    (req_tag_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_id_high     (rsp_id_high),
      .rsp_id_low      (rsp_id_low)
   );

endmodule

// File: test/testbench.sv
// Self-checking testbench for the chained splitmix64 identifier derivation block.
module testbench;
   import idmix_pkg::*;

   // Cycles with no handshake on either side before the run is declared hung.
   localparam int IDLE_LIMIT = 5000;
   // Length of the deliberate receiver hold-offs.
   localparam int HOLD_CYCLES = 300;
   // Cycles allowed after the last expected word for stray output.
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_WORDS = 1600;

   // The 64-bit value that the mixer maps to zero, used to reach the all-zero pair.
   localparam logic [63:0] MIX_ZERO_IN = 64'h0 - GAMMA_ADD;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } ident_type;

   // Tracks the running halves and the identifiers still owed by the block.
   class ident_scoreboard;
      logic [63:0] run_hi;
      logic [63:0] run_lo;
      ident_type   owed_ids[$];
      int          errors;
      int          n_checked;

      function new();
         run_hi = '0;
         run_lo = '0;
         errors = 0;
         n_checked = 0;
      endfunction

      // One splitmix64 round: add the gamma, then the finalizer.
      function logic [63:0] splitmix(input logic [63:0] x);
         logic [63:0] v;
         v = x + GAMMA_ADD;
         v = (v ^ (v >> SHIFT_ONE)) * MUL_ONE;
         v = (v ^ (v >> SHIFT_TWO)) * MUL_TWO;
         return v ^ (v >> SHIFT_THREE);
      endfunction

      // Update the halves for an accepted word and queue its identifier if it is last.
      function void absorb_word(input logic cmd, input logic [63:0] ph,
                                input logic [63:0] pl, input logic [7:0] tb,
                                input logic last);
         ident_type id;
         if (cmd == CMD_START) begin
            run_hi = splitmix(ph ^ HIGH_SALT);
            run_lo = splitmix(pl);
         end else begin
            run_hi = splitmix(run_hi ^ {56'h0, tb});
            run_lo = splitmix(run_lo + run_hi);
         end
         if (last) begin
            id.hi = run_hi;
            id.lo = run_lo;
            // An all-zero identifier is reported with a high half of one.
            if (id.hi == '0 && id.lo == '0)
               id.hi = 64'h1;
            owed_ids.push_back(id);
         end
      endfunction

      // Compare a delivered identifier with the oldest one owed.
      function void check_ident(input logic [63:0] hi, input logic [63:0] lo);
         ident_type id;
         n_checked++;
         if (owed_ids.size() == 0) begin
            $display("%0t: unexpected word, id_high %h id_low %h", $time, hi, lo);
            errors++;
            return;
         end
         id = owed_ids.pop_front();
         if (hi !== id.hi) begin
            $display("%0t: id_high expected %h, got %h", $time, id.hi, hi);
            errors++;
         end
         if (lo !== id.lo) begin
            $display("%0t: id_low expected %h, got %h", $time, id.lo, lo);
            errors++;
         end
      endfunction

      function int owed();
         return owed_ids.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [63:0] req_parent_high;
   logic [63:0] req_parent_low;
   logic [7:0]  req_tag_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_id_high;
   logic [63:0] rsp_id_low;

   ident_scoreboard ids;
   int  words_sent;
   int  idle_cycles;
   bit  stimulus_done;

   id_derive_mix_hash_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_parent_high (req_parent_high),
      .req_parent_low  (req_parent_low),
      .req_tag_byte    (req_tag_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_id_high     (rsp_id_high),
      .rsp_id_low      (rsp_id_low)
   );

   // Clock with a period of 10.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // Random 64-bit operand with the extremes mixed in.
   function automatic logic [63:0] pick_wide();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      else
         return {$urandom, $urandom};
   endfunction

   // Record accepted words and check delivered identifiers at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         ids.absorb_word(req_cmd, req_parent_high, req_parent_low, req_tag_byte, req_last);
      if (!reset && rsp_valid && rsp_ready)
         ids.check_ident(rsp_id_high, rsp_id_low);
   end

   // Watchdog: give up after too many cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Offer one word, after a random gap, and hold it until it is accepted.
   task automatic send_word(input logic cmd, input logic [63:0] ph, input logic [63:0] pl,
                            input logic [7:0] tb, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_cmd         = cmd;
      req_parent_high = ph;
      req_parent_low  = pl;
      req_tag_byte    = tb;
      req_last        = last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      @(negedge clock);
   endtask

   // Start word with random parents, followed by a tag string of the given length.
   task automatic send_derivation(input int tag_len);
      send_word(CMD_START, pick_wide(), pick_wide(), 8'($urandom), tag_len == 0);
      for (int i = 0; i < tag_len; i++)
         send_word(CMD_TAG, pick_wide(), pick_wide(), 8'($urandom), i == tag_len - 1);
   endtask

   // Receiver: random stalls, plus two long hold-offs while the sender keeps going.
   initial begin
      int gap;
      int hold_at;
      hold_at = 40;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_at > 0 && ids.n_checked >= hold_at) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_at = (hold_at == 40) ? 150 : 0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(negedge clock);
      end
   end

   // Main sequence: reset, directed words, random derivations, drain and verdict.
   initial begin
      int r;
      int len;
      ids = new();
      words_sent = 0;
      idle_cycles = 0;
      stimulus_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_START;
      req_parent_high = '0;
      req_parent_low = '0;
      req_tag_byte = '0;
      req_last = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Tag words straight after reset absorb into the zero halves.
      send_word(CMD_TAG, '0, '0, 8'h00, 1'b1);
      send_word(CMD_TAG, '1, '1, 8'hff, 1'b0);
      send_word(CMD_TAG, '0, '1, 8'h5a, 1'b1);
      // Start marked last gives the identifier of an empty tag.
      send_word(CMD_START, '0, '0, 8'hff, 1'b1);
      send_word(CMD_START, '1, '1, 8'h00, 1'b1);
      send_word(CMD_START, '1, '1, 8'hff, 1'b0);
      send_word(CMD_TAG, '0, '0, 8'hff, 1'b0);
      send_word(CMD_TAG, '1, '0, 8'h00, 1'b0);
      send_word(CMD_TAG, '0, '1, 8'h80, 1'b1);
      // Parents that mix to zero in both halves force a high half of one.
      send_word(CMD_START, MIX_ZERO_IN ^ HIGH_SALT, MIX_ZERO_IN, 8'h3c, 1'b1);
      // The halves stay zero after the forced emission.
      send_word(CMD_TAG, '1, '1, 8'h00, 1'b1);
      // A start that is never finished, then a fresh start over it.
      send_word(CMD_START, 64'h0123456789abcdef, 64'hfedcba9876543210, 8'h01, 1'b0);
      send_word(CMD_START, MIX_ZERO_IN ^ HIGH_SALT, MIX_ZERO_IN, 8'h01, 1'b0);
      send_word(CMD_TAG, 64'h8000000000000000, 64'h1, 8'h01, 1'b1);
      send_word(CMD_START, 64'h1, 64'h8000000000000000, 8'h7f, 1'b0);
      send_word(CMD_TAG, '0, '0, 8'h7f, 1'b1);

      // Mostly complete derivations with random content, some stray and broken words.
      while (words_sent < RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               len = $urandom_range(0, 6);
            else if (r < 95)
               len = $urandom_range(7, 20);
            else
               len = $urandom_range(21, 48);
            send_derivation(len);
         end else if (r < 93) begin
            send_word(CMD_TAG, pick_wide(), pick_wide(), 8'($urandom), 1'($urandom));
         end else begin
            send_word(CMD_START, pick_wide(), pick_wide(), 8'($urandom), 1'b0);
         end
      end
      req_valid = 1'b0;
      stimulus_done = 1'b1;

      // Wait for every owed identifier, then watch a little longer for extras.
      while (ids.owed() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ids.errors == 0 && ids.owed() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: id_derive_mix_hash_core.f
rtl/idmix_pkg.sv
rtl/idmix_dp.sv
rtl/idmix_ctrl.sv
rtl/id_derive_mix_hash_core.sv
test/testbench.sv
